### rtl/core/dcm_pkg.sv
package dcm_pkg;

  localparam int unsigned BLOCK_MAX_DEF = 1024;

  localparam logic [15:0] ALPHA_RST = 16'd62259;
  localparam logic [22:0] LREF_RST  = 23'd83886;
  localparam logic [31:0] DB_SCALE  = 32'd394566;
  localparam logic [24:0] RMS_MAX   = 25'd33554431;
  localparam logic [25:0] Y_POS_MAX = 26'd33554431;
  localparam logic [25:0] Y_NEG_MAX = 26'd33554432;
  localparam logic [4:0]  LOG_TOP   = 5'd30;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LREF  = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FILT_GO,
    S_FILT_WT,
    S_SQ_GO,
    S_SQ_WT,
    S_ACC,
    S_DIV_GO,
    S_DIV_WT,
    S_SQRT_GO,
    S_SQRT_WT,
    S_LOG_LD,
    S_LOG_NORM,
    S_LOG_GO,
    S_LOG_WT,
    S_DB_CHK,
    S_DB_GO,
    S_DB_WT,
    S_EMIT
  } seq_state_t;

endpackage

### rtl/core/dcm_mul.sv
module dcm_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] acc_r;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= {32'd0, a};
      b_r   <= b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/core/dcm_div.sv
module dcm_div #(
  parameter int unsigned CNT_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      num,
  input  logic [CNT_W-1:0] den,
  output logic             done,
  output logic [63:0]      quot
);

  logic [63:0]      num_r;
  logic [CNT_W-1:0] rem_r;
  logic [6:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, num_r[63]};
  assign ge     = rem_sh >= {1'b0, den};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      num_r <= {num_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

### rtl/core/dcm_sqrt.sv
module dcm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, v_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // two radicand bits a cycle, one root bit out
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= v;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[33:0] : rem_sh[33:0];
      root_r <= {root_r[30:0], ge};
      v_r    <= {v_r[61:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/core/dc_block_rms_db_meter_unit.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_raw_slot, in_last_of_block
// out      output     out_valid / out_stall out_clean_sample, out_block_done,
//                                           out_rms_level, out_level_db
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One request at a time through a bit-serial multiplier.
// A mid-block request runs the filter product, the square and the accumulate.
// Block end adds the 64-step divide, the 32-step root and, for a nonzero root, two log2
// runs of 16 squares after up to 30 normalise shifts each; dB product if rms > lref.
// Synchronous active-low reset; a waiting result does not block the next
// request being taken, but it must leave before the next result is loaded.
module dc_block_rms_db_meter_unit #(
  parameter int unsigned BLOCK_MAX = dcm_pkg::BLOCK_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_raw_slot,
  input  logic                            in_last_of_block,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [25:0]              out_clean_sample,
  output logic                            out_block_done,
  output logic [24:0]                     out_rms_level,
  output logic [15:0]                     out_level_db,
  input  logic                            cfg_we,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcm_pkg::*;

  localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);

  seq_state_t state_r, state_nxt;

  logic [15:0]             alpha_r;
  logic [22:0]             lref_r;
  logic signed [23:0]      x_r;
  logic                    last_r;
  logic signed [23:0]      prev_in_r;
  logic signed [25:0]      prev_out_r;
  logic [25:0]             ymag_r;
  logic [63:0]             sq_r;
  logic [63:0]             sum_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    blk_r;
  logic [24:0]             rms_r;
  logic [15:0]             db_r;
  logic [30:0]             m_r;
  logic [4:0]              n_r;
  logic [15:0]             frac_r;
  logic [3:0]              it_r;
  logic                    sel_r;
  logic [20:0]             lr_r;
  logic [20:0]             d_r;
  logic                    out_valid_r;
  logic signed [25:0]      out_clean_r;
  logic                    out_done_r;
  logic [24:0]             out_rms_r;
  logic [15:0]             out_db_r;

  logic                    mul_start, div_start, sqrt_start;
  logic                    mul_done, div_done, sqrt_done;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             mul_prod, div_quot;
  logic [31:0]             sqrt_root;
  logic                    emit_ok;

  logic signed [27:0]      s_w;
  logic                    s_neg;
  logic [27:0]             s_mag;
  logic [44:0]             rnd_w;
  logic [28:0]             ym_w;
  logic [25:0]             mag_w;
  logic [64:0]             sum_w;
  logic [CNT_W:0]          cnt_inc;
  logic                    end_w;
  logic [31:0]             t_w;
  logic [15:0]             frac_w;
  logic [20:0]             lf_w;
  logic [22:0]             ref_w;

  assign s_w   = 28'(prev_out_r) + 28'(x_r) - 28'(prev_in_r);
  assign s_neg = s_w[27];
  assign s_mag = s_neg ? 28'(-s_w) : 28'(s_w);
  assign rnd_w = {1'b0, mul_prod[43:0]} + (s_neg ? 45'd65535 : 45'd0);
  assign ym_w  = rnd_w[44:16];

  always_comb begin
    if (s_neg) begin
      mag_w = (ym_w > 29'(Y_NEG_MAX)) ? Y_NEG_MAX : ym_w[25:0];
    end else begin
      mag_w = (ym_w > 29'(Y_POS_MAX)) ? Y_POS_MAX : ym_w[25:0];
    end
  end

  assign sum_w   = {1'b0, sum_r} + {1'b0, sq_r};
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign end_w   = last_r || (cnt_inc >= (CNT_W + 1)'(BLOCK_MAX));
  assign t_w     = mul_prod[61:30];
  assign frac_w  = frac_r | (t_w[31] ? (16'd1 << it_r) : 16'd0);
  assign lf_w    = {n_r, frac_r};
  assign ref_w   = (lref_r == 23'd0) ? 23'd1 : lref_r;
  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_FILT_GO;
      S_FILT_GO:  state_nxt = S_FILT_WT;
      S_FILT_WT:  if (mul_done) state_nxt = S_SQ_GO;
      S_SQ_GO:    state_nxt = S_SQ_WT;
      S_SQ_WT:    if (mul_done) state_nxt = S_ACC;
      S_ACC:      state_nxt = end_w ? S_DIV_GO : S_EMIT;
      S_DIV_GO:   state_nxt = S_DIV_WT;
      S_DIV_WT:   if (div_done) state_nxt = S_SQRT_GO;
      S_SQRT_GO:  state_nxt = S_SQRT_WT;
      S_SQRT_WT:  if (sqrt_done) state_nxt = (sqrt_root == 32'd0) ? S_EMIT : S_LOG_LD;
      S_LOG_LD:   state_nxt = S_LOG_NORM;
      S_LOG_NORM: if (m_r[30]) state_nxt = S_LOG_GO;
      S_LOG_GO:   state_nxt = S_LOG_WT;
      S_LOG_WT: begin
        if (mul_done) begin
          if (it_r != 4'd0) state_nxt = S_LOG_GO;
          else state_nxt = sel_r ? S_DB_CHK : S_LOG_LD;
        end
      end
      S_DB_CHK:   state_nxt = (lr_r > lf_w) ? S_DB_GO : S_EMIT;
      S_DB_GO:    state_nxt = S_DB_WT;
      S_DB_WT:    if (mul_done) state_nxt = S_EMIT;
      S_EMIT:     if (emit_ok) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE:    in_stall = 1'b0;
      S_FILT_GO: begin
        mul_start = 1'b1;
        mul_a     = {4'd0, s_mag};
        mul_b     = {16'd0, alpha_r};
      end
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = {6'd0, ymag_r};
        mul_b     = {6'd0, ymag_r};
      end
      S_LOG_GO: begin
        mul_start = 1'b1;
        mul_a     = {1'b0, m_r};
        mul_b     = {1'b0, m_r};
      end
      S_DB_GO: begin
        mul_start = 1'b1;
        mul_a     = {11'd0, d_r};
        mul_b     = DB_SCALE;
      end
      S_DIV_GO:  div_start  = 1'b1;
      S_SQRT_GO: sqrt_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= ALPHA_RST;
      lref_r      <= LREF_RST;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALPHA: alpha_r <= cfg_data[15:0];
          CFG_LREF:  lref_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == S_FILT_WT && mul_done) begin
        prev_in_r  <= x_r;
        prev_out_r <= s_neg ? -$signed(mag_w) : $signed(mag_w);
      end
      if (state_r == S_ACC) begin
        sum_r <= sum_w[64] ? '1 : sum_w[63:0];
        cnt_r <= cnt_inc[CNT_W-1:0];
      end
      if (state_r == S_DIV_WT && div_done) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r    <= in_raw_slot[31:8];
        last_r <= in_last_of_block;
      end
      S_FILT_WT: if (mul_done) ymag_r <= mag_w;
      S_SQ_WT:   if (mul_done) sq_r <= mul_prod;
      S_ACC: begin
        blk_r <= end_w;
        rms_r <= '0;
        db_r  <= '0;
      end
      S_SQRT_WT: begin
        if (sqrt_done) begin
          rms_r <= (sqrt_root > 32'(RMS_MAX)) ? RMS_MAX : sqrt_root[24:0];
          sel_r <= 1'b0;
        end
      end
      S_LOG_LD: begin
        m_r    <= sel_r ? {8'd0, ref_w} : {6'd0, rms_r};
        n_r    <= LOG_TOP;
        frac_r <= '0;
        it_r   <= 4'd15;
      end
      S_LOG_NORM: begin
        if (!m_r[30]) begin
          m_r <= {m_r[29:0], 1'b0};
          n_r <= n_r - 5'd1;
        end
      end
      S_LOG_WT: begin
        if (mul_done) begin
          m_r    <= t_w[31] ? t_w[31:1] : t_w[30:0];
          frac_r <= frac_w;
          it_r   <= it_r - 4'd1;
          if (it_r == 4'd0 && !sel_r) begin
            lr_r  <= {n_r, frac_w};
            sel_r <= 1'b1;
          end
        end
      end
      S_DB_CHK: d_r <= lr_r - lf_w;
      S_DB_WT:  if (mul_done) db_r <= (|mul_prod[63:40]) ? 16'hFFFF : mul_prod[39:24];
      S_EMIT: begin
        if (emit_ok) begin
          out_clean_r <= prev_out_r;
          out_done_r  <= blk_r;
          out_rms_r   <= rms_r;
          out_db_r    <= db_r;
        end
      end
      default: begin
      end
    endcase
  end

  dcm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dcm_div #(.CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  dcm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign out_valid        = out_valid_r;
  assign out_clean_sample = out_clean_r;
  assign out_block_done   = out_done_r;
  assign out_rms_level    = out_rms_r;
  assign out_level_db     = out_db_r;

endmodule
